// ===== hdl/cbdl4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbdl4_pkg
// Types and constants shared by the 4-D city-block distance labelling unit
// and its checker.
// ----------------------------------------------------------------------------
package cbdl4_pkg;

   // field and register widths
   localparam int LABEL_W   = 4;
   localparam int DIM_W     = 9;
   localparam int LEVEL_W   = 5;
   localparam int INDEX_W   = 16;
   localparam int MODE_W    = 2;
   localparam int DIM_COUNT = 4;
   localparam int VOL_W     = DIM_COUNT * DIM_W;
   localparam int PADDR_W   = 5;
   localparam int PDATA_W   = 32;

   // register reset values
   localparam logic [DIM_W-1:0]   DIM_RESET   = 9'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_RESET = 5'd16;

   // cycles for the volume size products to settle after a register write
   localparam int                 SETTLE_W      = 2;
   localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

   // per-voxel sequencer steps: self read, four neighbor reads, write back
   localparam int                STEP_W     = 3;
   localparam logic [STEP_W-1:0] STEP_SELF  = 3'd0;
   localparam logic [STEP_W-1:0] STEP_FIRST = 3'd1;
   localparam logic [STEP_W-1:0] STEP_LAST  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_WRITE = 3'd5;

   // response status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // command codes
   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_READ = 2'd2,
      MODE_NOP  = 2'd3
   } mode_type;

   // register indexes (byte address / 4)
   typedef enum logic [PADDR_W-3:0] {
      REG_DIM_X = 3'd0,
      REG_DIM_Y = 3'd1,
      REG_DIM_Z = 3'd2,
      REG_DIM_T = 3'd3,
      REG_LEVEL = 3'd4
   } reg_index_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FWD,
      ST_BWD
   } state_type;

endpackage

// ===== hdl/city_block_distance_label_4d_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// city_block_distance_label_4d_unit
// Capped city-block distance labels over a 4-D voxel volume held in one
// label memory; load seed flags, run forward and backward raster passes,
// read labels back.
// ----------------------------------------------------------------------------
// Load, read and no-op transactions: result in the cycle after acceptance;
// one transaction per cycle while the unit is not busy.
// Run: a forward and a backward pass; each voxel has a self read and four
// neighbor reads through the single memory read port, then the write back.
// Reset and every register write hold busy while the volume size products
// settle. The label memory is not cleared; the user must load every voxel
// before use, unenforced by the unit. Results strobe one cycle, cannot stall.
module city_block_distance_label_4d_unit #(
   parameter int VOXELS     = 65536,
   parameter int MAX_LEVELS = 16,
   parameter int DIM_MAX    = 256
) (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                start,
   output logic                                busy,
   input  logic [cbdl4_pkg::MODE_W-1:0]        req_mode,
   input  logic [cbdl4_pkg::INDEX_W-1:0]       req_voxel_index,
   input  logic                                req_seed,
   // result channel
   output logic                                rsp_valid,
   output logic [cbdl4_pkg::LABEL_W-1:0]       rsp_label,
   output logic                                rsp_status,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cbdl4_pkg::PADDR_W-1:0]       paddr,
   input  logic [cbdl4_pkg::PDATA_W-1:0]       pwdata,
   output logic [cbdl4_pkg::PDATA_W-1:0]       prdata,
   output logic                                pready
);
   import cbdl4_pkg::*;

   localparam int                AW        = $clog2(VOXELS);
   localparam logic [VOL_W-1:0]  VOX_LIMIT = VOL_W'(VOXELS);

   // configuration registers
   logic [DIM_W-1:0]          dims_ff [DIM_COUNT];
   logic [LEVEL_W-1:0]        level_ff;
   logic                      csr_wr;
   logic [PADDR_W-3:0]        reg_idx;

   // volume size pipeline
   logic [2*DIM_W-1:0]        s2_ff;
   logic [3*DIM_W-1:0]        s3_ff;
   logic [VOL_W-1:0]          n_ff;
   logic [2*DIM_W-1:0]        s2_in;
   logic [3*DIM_W-1:0]        s3_in;
   logic [VOL_W-1:0]          n_in;
   logic                      dims_ok_ff;
   logic                      dims_ok_in;
   logic                      vol_ok_ff;
   logic [SETTLE_W-1:0]       settle_ff;

   // label cap
   logic [LEVEL_W-1:0]        eff_level;
   logic [LABEL_W-1:0]        cap;

   // sequencer
   state_type                 state_ff, state_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [DIM_W-1:0]          coord_ff [DIM_COUNT];
   logic [DIM_W-1:0]          coord_in [DIM_COUNT];
   logic [AW-1:0]             vox_ff, vox_in;
   logic [LABEL_W-1:0]        acc_ff, acc_in;
   logic [AW-1:0]             n_last;

   // neighbor addressing and raster stepping
   logic [AW-1:0]             stride [DIM_COUNT];
   logic                      has_lo [DIM_COUNT];
   logic                      has_hi [DIM_COUNT];
   logic [AW-1:0]             nb_addr [DIM_COUNT];
   logic [DIM_W-1:0]          fwd_next [DIM_COUNT];
   logic [DIM_W-1:0]          bwd_next [DIM_COUNT];
   logic                      carry_v, borrow_v;

   // relaxation
   logic [LABEL_W:0]          q_inc;
   logic [LABEL_W-1:0]        cand;
   logic [LABEL_W-1:0]        relax_min;

   // memory
   logic [LABEL_W-1:0]        label_mem [VOXELS];
   logic [LABEL_W-1:0]        mem_q_ff;
   logic [AW-1:0]             rd_addr, wr_addr;
   logic                      mem_we;
   logic [LABEL_W-1:0]        wr_data;

   // command decode and response
   logic                      accept;
   mode_type                  mode_e;
   logic                      idx_ok;
   logic                      rsp_fire, rsp_err, rsp_read;
   logic                      rsp_valid_ff, rsp_status_ff, rsp_read_ff;

   // register port
   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign reg_idx = paddr[PADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < DIM_COUNT; a++) dims_ff[a] <= DIM_RESET;
         level_ff <= LEVEL_RESET;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_DIM_X: dims_ff[0] <= pwdata[DIM_W-1:0];
            REG_DIM_Y: dims_ff[1] <= pwdata[DIM_W-1:0];
            REG_DIM_Z: dims_ff[2] <= pwdata[DIM_W-1:0];
            REG_DIM_T: dims_ff[3] <= pwdata[DIM_W-1:0];
            REG_LEVEL: level_ff   <= pwdata[LEVEL_W-1:0];
            default:   ;
         endcase
      end
   end

   // register read back
   always_comb begin
      unique case (reg_idx)
         REG_DIM_X: prdata = PDATA_W'(dims_ff[0]);
         REG_DIM_Y: prdata = PDATA_W'(dims_ff[1]);
         REG_DIM_Z: prdata = PDATA_W'(dims_ff[2]);
         REG_DIM_T: prdata = PDATA_W'(dims_ff[3]);
         REG_LEVEL: prdata = PDATA_W'(level_ff);
         default:   prdata = '0;
      endcase
   end

   // volume size: three registered multiplies
   assign s2_in = dims_ff[0] * dims_ff[1];
   assign s3_in = s2_ff * dims_ff[2];
   assign n_in  = s3_ff * dims_ff[3];

   always_comb begin
      dims_ok_in = 1'b1;
      for (int a = 0; a < DIM_COUNT; a++) begin
         if (dims_ff[a] == '0 || 32'(dims_ff[a]) > DIM_MAX) dims_ok_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s2_ff      <= s2_in;
      s3_ff      <= s3_in;
      n_ff       <= n_in;
      dims_ok_ff <= dims_ok_in;
      vol_ok_ff  <= dims_ok_ff && (n_in <= VOX_LIMIT);
   end

   // hold off commands until the size products match the registers
   always_ff @(posedge clock) begin
      if (reset || csr_wr) begin
         settle_ff <= SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_ff <= settle_ff - SETTLE_W'(1);
      end
   end

   // effective label cap
   always_comb begin
      if (level_ff == '0) begin
         eff_level = LEVEL_W'(1);
      end else if (32'(level_ff) > MAX_LEVELS) begin
         eff_level = LEVEL_W'(MAX_LEVELS);
      end else begin
         eff_level = level_ff;
      end
      cap = LABEL_W'(eff_level - LEVEL_W'(1));
   end

   // handshake
   assign busy   = (state_ff != ST_IDLE) || (settle_ff != '0);
   assign accept = start && !busy;
   assign mode_e = mode_type'(req_mode);
   assign idx_ok = VOL_W'(req_voxel_index) < n_ff;
   assign n_last = AW'(n_ff - VOL_W'(1));

   // strides and neighbor addresses for the current voxel
   assign stride[0] = AW'(1);
   assign stride[1] = AW'(dims_ff[0]);
   assign stride[2] = AW'(s2_ff);
   assign stride[3] = AW'(s3_ff);

   always_comb begin
      for (int a = 0; a < DIM_COUNT; a++) begin
         has_lo[a] = coord_ff[a] != '0;
         has_hi[a] = ({1'b0, coord_ff[a]} + (DIM_W+1)'(1)) < {1'b0, dims_ff[a]};
         if (state_ff == ST_BWD) begin
            nb_addr[a] = has_hi[a] ? vox_ff + stride[a] : vox_ff;
         end else begin
            nb_addr[a] = has_lo[a] ? vox_ff - stride[a] : vox_ff;
         end
      end
   end

   // raster stepping of the coordinates
   always_comb begin
      carry_v  = 1'b1;
      borrow_v = 1'b1;
      for (int a = 0; a < DIM_COUNT; a++) begin
         fwd_next[a] = coord_ff[a];
         bwd_next[a] = coord_ff[a];
         if (carry_v) begin
            if (has_hi[a]) begin
               fwd_next[a] = coord_ff[a] + DIM_W'(1);
               carry_v     = 1'b0;
            end else begin
               fwd_next[a] = '0;
            end
         end
         if (borrow_v) begin
            if (has_lo[a]) begin
               bwd_next[a] = coord_ff[a] - DIM_W'(1);
               borrow_v    = 1'b0;
            end else begin
               bwd_next[a] = dims_ff[a] - DIM_W'(1);
            end
         end
      end
   end

   // neighbor label plus one, capped, against the running minimum
   assign q_inc     = {1'b0, mem_q_ff} + (LABEL_W+1)'(1);
   assign cand      = (q_inc > {1'b0, cap}) ? cap : q_inc[LABEL_W-1:0];
   assign relax_min = (cand < acc_ff) ? cand : acc_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && mode_e == MODE_RUN && vol_ok_ff) state_in = ST_FWD;
         end
         ST_FWD: begin
            if (step_ff == STEP_WRITE && vox_ff == n_last) state_in = ST_BWD;
         end
         ST_BWD: begin
            if (step_ff == STEP_WRITE && vox_ff == '0) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and datapath updates
   always_comb begin
      step_in  = step_ff;
      coord_in = coord_ff;
      vox_in   = vox_ff;
      acc_in   = acc_ff;
      rd_addr  = vox_ff;
      mem_we   = 1'b0;
      wr_addr  = vox_ff;
      wr_data  = relax_min;
      rsp_fire = 1'b0;
      rsp_err  = STATUS_OK;
      rsp_read = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            rd_addr  = AW'(req_voxel_index);
            step_in  = STEP_SELF;
            coord_in = '{default: '0};
            vox_in   = '0;
            if (accept) begin
               rsp_fire = 1'b1;
               unique case (mode_e)
                  MODE_LOAD: begin
                     if (!vol_ok_ff || !idx_ok) begin
                        rsp_err = STATUS_ERR;
                     end else begin
                        mem_we  = 1'b1;
                        wr_addr = AW'(req_voxel_index);
                        wr_data = req_seed ? '0 : cap;
                     end
                  end
                  MODE_RUN: begin
                     if (!vol_ok_ff) rsp_err  = STATUS_ERR;
                     else            rsp_fire = 1'b0;
                  end
                  MODE_READ: begin
                     if (!vol_ok_ff || !idx_ok) rsp_err  = STATUS_ERR;
                     else                       rsp_read = 1'b1;
                  end
                  MODE_NOP: ;
                  default:  ;
               endcase
            end
         end
         ST_FWD, ST_BWD: begin
            // step 0 reads the voxel itself, steps 1..4 its neighbors
            if (step_ff == STEP_SELF) begin
               rd_addr = vox_ff;
            end else begin
               rd_addr = nb_addr[2'(step_ff - STEP_FIRST)];
            end
            if (step_ff == STEP_WRITE) begin
               mem_we  = 1'b1;
               step_in = STEP_SELF;
               if (state_ff == ST_FWD) begin
                  if (vox_ff == n_last) begin
                     for (int a = 0; a < DIM_COUNT; a++) begin
                        coord_in[a] = dims_ff[a] - DIM_W'(1);
                     end
                     vox_in = n_last;
                  end else begin
                     coord_in = fwd_next;
                     vox_in   = vox_ff + AW'(1);
                  end
               end else begin
                  if (vox_ff == '0) begin
                     rsp_fire = 1'b1;
                  end else begin
                     coord_in = bwd_next;
                     vox_in   = vox_ff - AW'(1);
                  end
               end
            end else begin
               step_in = step_ff + STEP_W'(1);
               if (step_ff == STEP_FIRST) begin
                  acc_in = mem_q_ff;
               end else if (step_ff > STEP_FIRST && step_ff <= STEP_LAST) begin
                  acc_in = relax_min;
               end
            end
         end
         default: ;
      endcase
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_SELF;
         coord_ff <= '{default: '0};
         vox_ff   <= '0;
         acc_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         coord_ff <= coord_in;
         vox_ff   <= vox_in;
         acc_ff   <= acc_in;
      end
   end

   // label memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) label_mem[wr_addr] <= wr_data;
      mem_q_ff <= label_mem[rd_addr];
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STATUS_OK;
         rsp_read_ff   <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_fire;
         rsp_status_ff <= rsp_err;
         rsp_read_ff   <= rsp_read;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_label  = rsp_read_ff ? mem_q_ff : '0;

endmodule

// ===== hdl/cbdl4_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbdl4_checker
// Port-level checks for the 4-D city-block distance labelling unit.
// ----------------------------------------------------------------------------
module cbdl4_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [cbdl4_pkg::MODE_W-1:0]        req_mode,
   input logic                                rsp_valid,
   input logic [cbdl4_pkg::LABEL_W-1:0]       rsp_label,
   input logic                                rsp_status,
   input logic                                psel,
   input logic                                penable,
   input logic                                pwrite,
   input logic                                pready
);
   import cbdl4_pkg::*;

   // load, read and no-op transactions answer in the next cycle
   a_short_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode != MODE_RUN) |=> rsp_valid)
      else $error("short transaction gave no result in the next cycle");

   // a run either fails at once or keeps the unit busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode == MODE_RUN) |=> (busy || (rsp_valid && rsp_status)))
      else $error("run transaction neither busy nor rejected");

   // a label only shows on a successful read result
   a_label_gate: assert property (@(posedge clock) disable iff (reset)
      (rsp_label != '0) |-> (rsp_valid && rsp_status == STATUS_OK))
      else $error("label shown outside a successful read");

   // a register write blocks commands while the size products settle
   a_cfg_busy: assert property (@(posedge clock) disable iff (reset)
      (psel && penable && pwrite && pready) |=> busy)
      else $error("unit not busy after a register write");

endmodule

bind city_block_distance_label_4d_unit cbdl4_checker u_cbdl4_checker (.*);
